// File: hw/rtl/gapped_sequence_mismatch_counter_core_defines.svh
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef GAPPED_SEQUENCE_MISMATCH_COUNTER_CORE_DEFINES_SVH
`define GAPPED_SEQUENCE_MISMATCH_COUNTER_CORE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GSMC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define GSMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gsmc_pkg.sv
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - package
// Widths, register indexes and the types passed between lanes and merge.
// ---------------------------------------------------------------------------
`default_nettype none

package gsmc_pkg;

    localparam int BYTE_W      = 8;
    localparam int CHUNK_BYTES = 8;
    localparam int CHUNK_W     = BYTE_W * CHUNK_BYTES;
    localparam int CNT_W       = 21;
    localparam int LANE_CNT_W  = 4;
    localparam int CFG_IDX_W   = 8;

    typedef logic [BYTE_W-1:0]     t_byte;
    typedef logic [CHUNK_W-1:0]    t_chunk;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [LANE_CNT_W-1:0] t_lane_cnt;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_index;

    localparam t_cfg_index REG_PADDED_LENGTH = t_cfg_index'(0);
    localparam t_cfg_index REG_GAP_CODE      = t_cfg_index'(1);

    localparam t_byte GAP_CODE_RST = t_byte'(45);
    localparam t_cnt  CNT_MAX      = {CNT_W{1'b1}};

    typedef struct packed {
        logic gap;
        logic mis;
    } t_lane_flag;

    typedef struct packed {
        t_lane_cnt gap;
        t_lane_cnt mis;
    } t_chunk_cnt;

endpackage

`default_nettype wire

// File: hw/rtl/gsmc_lane.sv
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - lane
// Classifies one residue position as gap, mismatch or match.
// ---------------------------------------------------------------------------
`default_nettype none

module gsmc_lane (
    input  gsmc_pkg::t_byte      i_byte_a,
    input  gsmc_pkg::t_byte      i_byte_b,
    input  gsmc_pkg::t_byte      i_gap_code,
    output gsmc_pkg::t_lane_flag o_flag
);
    import gsmc_pkg::*;

    logic is_gap;

    assign is_gap     = (i_byte_a == i_gap_code) || (i_byte_b == i_gap_code);
    assign o_flag.gap = is_gap;
    assign o_flag.mis = !is_gap && (i_byte_a != i_byte_b);

endmodule

`default_nettype wire

// File: hw/rtl/gsmc_merge.sv
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - merge
// Counts gap and mismatch flags across all lanes of one chunk.
// ---------------------------------------------------------------------------
`default_nettype none

module gsmc_merge #(
    parameter int LANES = 8
) (
    input  gsmc_pkg::t_lane_flag [LANES-1:0] i_flags,
    output gsmc_pkg::t_chunk_cnt             o_cnt
);
    import gsmc_pkg::*;

    always_comb begin
        o_cnt = '0;
        for (int i = 0; i < LANES; i++) begin
            o_cnt.gap = o_cnt.gap + t_lane_cnt'(i_flags[i].gap);
            o_cnt.mis = o_cnt.mis + t_lane_cnt'(i_flags[i].mis);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gapped_sequence_mismatch_counter_core.sv
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - top level
// Running gap and mismatch totals over aligned residue chunks.
// ---------------------------------------------------------------------------
// One chunk is taken every cycle unless held off. LANES byte comparators
// classify the positions of a chunk, a merge stage counts the flags, and
// the saturating totals update in the same cycle. The result of a final
// chunk sits in the output register in the cycle after that chunk's
// transaction; input is held off only in reset and while that register
// holds a result that downstream has not taken. Positions above lane
// LANES-1 are ignored. Register writes are taken every cycle out of reset.
`default_nettype none

module gapped_sequence_mismatch_counter_core #(
    parameter int LANES = 8
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_ready,
    input  gsmc_pkg::t_chunk       i_chunk_a,
    input  gsmc_pkg::t_chunk       i_chunk_b,
    input  wire                    i_last_chunk,
    output logic                   o_valid,
    input  wire                    i_ready,
    output gsmc_pkg::t_cnt         o_mismatch_count,
    output gsmc_pkg::t_cnt         o_compared_length,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  gsmc_pkg::t_cfg_index   i_cfg_index,
    input  gsmc_pkg::t_cnt         i_cfg_data
);
    import gsmc_pkg::*;

    function automatic t_cnt sat_add(input t_cnt acc, input t_lane_cnt inc);
        logic [CNT_W:0] sum;
        sum = {1'b0, acc} + (CNT_W + 1)'(inc);
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    t_cnt  r_padded_length;
    t_byte r_gap_code;
    t_cnt  r_mis_total, n_mis_total;
    t_cnt  r_gap_total, n_gap_total;
    logic  r_out_valid;
    t_cnt  r_mismatch_count;
    t_cnt  r_compared_length;
    t_cnt  n_compared_length;

    t_lane_flag [LANES-1:0] lane_flags;
    t_chunk_cnt             chunk_cnt;
    logic                   in_xact;
    logic                   out_xact;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        gsmc_lane u_lane (
            .i_byte_a   (i_chunk_a[BYTE_W*g +: BYTE_W]),
            .i_byte_b   (i_chunk_b[BYTE_W*g +: BYTE_W]),
            .i_gap_code (r_gap_code),
            .o_flag     (lane_flags[g])
        );
    end

    gsmc_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_flags (lane_flags),
        .o_cnt   (chunk_cnt)
    );

    assign o_ready     = i_rst_n && (!r_out_valid || i_ready);
    assign o_cfg_ready = i_rst_n;
    assign in_xact     = i_valid && o_ready;
    assign out_xact    = r_out_valid && i_ready;

    assign n_mis_total       = sat_add(r_mis_total, chunk_cnt.mis);
    assign n_gap_total       = sat_add(r_gap_total, chunk_cnt.gap);
    assign n_compared_length = (r_padded_length > n_gap_total) ?
                               (r_padded_length - n_gap_total) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_padded_length <= '0;
            r_gap_code      <= GAP_CODE_RST;
            r_mis_total     <= '0;
            r_gap_total     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_PADDED_LENGTH: r_padded_length <= i_cfg_data;
                    REG_GAP_CODE:      r_gap_code      <= i_cfg_data[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (in_xact) begin
                r_mis_total <= i_last_chunk ? '0 : n_mis_total;
                r_gap_total <= i_last_chunk ? '0 : n_gap_total;
            end
            if (in_xact && i_last_chunk) begin
                r_out_valid <= 1'b1;
            end else if (out_xact) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact && i_last_chunk) begin
            r_mismatch_count  <= n_mis_total;
            r_compared_length <= n_compared_length;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mismatch_count  = r_mismatch_count;
    assign o_compared_length = r_compared_length;

endmodule

`default_nettype wire

// File: hw/rtl/gsmc_checker.sv
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - port checker
// Watches the top-level ports for output handshake and result timing.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gapped_sequence_mismatch_counter_core_defines.svh"

module gsmc_checker (
    input wire            i_clk,
    input wire            i_rst_n,
    input wire            i_valid,
    input wire            o_ready,
    input wire            i_last_chunk,
    input wire            o_valid,
    input wire            i_ready,
    input gsmc_pkg::t_cnt o_mismatch_count,
    input gsmc_pkg::t_cnt o_compared_length
);
    import gsmc_pkg::*;

    logic last_xact;

    assign last_xact = i_valid && o_ready && i_last_chunk;

    `GSMC_ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `GSMC_ASSERT_NEXT(a_out_data_holds, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_mismatch_count) && $stable(o_compared_length), "result changed while stalled")
    `GSMC_ASSERT_IMPLY(a_result_from_last, i_clk, i_rst_n, $rose(o_valid), $past(last_xact), "result without final chunk")
    `GSMC_ASSERT_NEXT(a_result_retires, i_clk, i_rst_n, o_valid && i_ready && !last_xact, !o_valid, "result repeated")
    `GSMC_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready, "input stalled with empty output")

endmodule

bind gapped_sequence_mismatch_counter_core gsmc_checker u_gsmc_checker (.*);

`default_nettype wire

// File: tb/sv/tb_gapped_sequence_mismatch_counter_core.sv
// ---------------------------------------------------------------------------
// Gapped sequence mismatch counter - testbench
// Streams aligned residue chunks through the core, predicts the mismatch
// and compared-length tally of every sequence pair, and checks each output
// transaction against it. Directed tests cover reset defaults, lane classes
// and register extremes. Randomized traffic runs under three idle profiles.
// ---------------------------------------------------------------------------
module tb_gapped_sequence_mismatch_counter_core;

    import gsmc_pkg::*;

    localparam int LANES = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int BLOCK_ITEMS = 150;
    localparam t_byte DASH = GAP_CODE_RST;
    localparam t_cfg_index REG_UNUSED_LOW = t_cfg_index'(2);
    localparam t_cfg_index REG_UNUSED_TOP = '1;

    typedef struct packed {
        t_cnt mismatch_count;
        t_cnt compared_length;
    } t_tally_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_chunk     i_chunk_a;
    t_chunk     i_chunk_b;
    logic       i_last_chunk;
    logic       o_valid;
    logic       i_ready;
    t_cnt       o_mismatch_count;
    t_cnt       o_compared_length;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index;
    t_cnt       i_cfg_data;

    t_tally_result expected_tallies[$];
    int            error_count;
    int            src_idle_pct;
    int            snk_idle_pct;

    t_cnt  pad_len_reg;
    t_byte gap_sym_reg;
    t_cnt  mis_total;
    t_cnt  gap_total;

    gapped_sequence_mismatch_counter_core #(
        .LANES(LANES)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_chunk_a         (i_chunk_a),
        .i_chunk_b         (i_chunk_b),
        .i_last_chunk      (i_last_chunk),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_mismatch_count  (o_mismatch_count),
        .o_compared_length (o_compared_length),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_cnt sat_add(input t_cnt acc, input int unsigned inc);
        int unsigned s;
        s = acc + inc;
        return (s > CNT_MAX) ? CNT_MAX : t_cnt'(s);
    endfunction

    function automatic void predict_chunk(input t_chunk a, input t_chunk b,
                                          input logic is_last);
        int unsigned mis;
        int unsigned gaps;
        int          lane;
        t_byte       ba;
        t_byte       bb;
        t_tally_result res;
        mis  = 0;
        gaps = 0;
        for (lane = 0; lane < LANES; lane++) begin
            ba = a[lane*8 +: 8];
            bb = b[lane*8 +: 8];
            if (ba == gap_sym_reg || bb == gap_sym_reg) begin
                gaps++;
            end else if (ba != bb) begin
                mis++;
            end
        end
        mis_total = sat_add(mis_total, mis);
        gap_total = sat_add(gap_total, gaps);
        if (is_last) begin
            res.mismatch_count  = mis_total;
            res.compared_length = (pad_len_reg > gap_total) ? t_cnt'(pad_len_reg - gap_total)
                                                            : '0;
            expected_tallies.push_back(res);
            mis_total = '0;
            gap_total = '0;
        end
    endfunction

    function automatic void make_residue_pair(input t_byte gap, output t_chunk a,
                                              output t_chunk b);
        int    lane;
        t_byte ra;
        t_byte rb;
        for (lane = 0; lane < CHUNK_BYTES; lane++) begin
            ra = t_byte'($urandom);
            rb = t_byte'($urandom);
            case ($urandom_range(7))
                0, 1: rb = ra;
                2:    rb = ra ^ t_byte'($urandom_range(1, 255));
                3:    ra = gap;
                4:    rb = gap;
                5: begin
                    ra = gap;
                    rb = gap;
                end
                default: ;
            endcase
            a[lane*8 +: 8] = ra;
            b[lane*8 +: 8] = rb;
        end
    endfunction

    task automatic send_chunk(input t_chunk a, input t_chunk b, input logic is_last);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_chunk_a    <= a;
        i_chunk_b    <= b;
        i_last_chunk <= is_last;
        do @(posedge i_clk); while (!o_ready);
        predict_chunk(a, b, is_last);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_tallies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input t_cnt data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_PADDED_LENGTH) begin
            pad_len_reg = data;
        end else if (idx == REG_GAP_CODE) begin
            gap_sym_reg = data[7:0];
        end
    endtask

    task automatic release_cfg();
        i_cfg_valid <= 1'b0;
    endtask

    // result check and downstream backpressure
    always @(posedge i_clk) begin : result_check
        t_tally_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_tallies.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction mismatch_count=%0d compared_length=%0d",
                         $time, o_mismatch_count, o_compared_length);
            end else begin
                want = expected_tallies.pop_front();
                if (o_mismatch_count !== want.mismatch_count) begin
                    error_count++;
                    $display("%0t: mismatch_count expected %0d actual %0d",
                             $time, want.mismatch_count, o_mismatch_count);
                end
                if (o_compared_length !== want.compared_length) begin
                    error_count++;
                    $display("%0t: compared_length expected %0d actual %0d",
                             $time, want.compared_length, o_compared_length);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic test_reset_defaults();
        send_chunk({CHUNK_BYTES{DASH}}, '0, 1'b0);
        send_chunk(64'h1, 64'h2, 1'b1);
        drain_results();
    endtask

    task automatic test_lane_classes();
        write_reg(REG_PADDED_LENGTH, t_cnt'(128));
        write_reg(REG_GAP_CODE, t_cnt'(DASH));
        release_cfg();
        send_chunk(64'h4142_4344_4546_4748, 64'h4142_4344_4546_4748, 1'b1);
        send_chunk('0, '1, 1'b1);
        send_chunk({CHUNK_BYTES{DASH}}, 64'h1234_5678_9ABC_DEF0, 1'b1);
        send_chunk(64'h0F1E_2D3C_4B5A_6978, {CHUNK_BYTES{DASH}}, 1'b1);
        send_chunk({CHUNK_BYTES{DASH}}, {CHUNK_BYTES{DASH}}, 1'b1);
        send_chunk(64'h2D00_2D00_2D00_2D00, 64'h0011_2D22_0033_2D44, 1'b1);
        send_chunk(64'h1, 64'h0, 1'b1);
        send_chunk(64'h8000_0000_0000_0000, 64'h0, 1'b1);
        send_chunk({CHUNK_BYTES{8'hAA}}, {CHUNK_BYTES{8'h55}}, 1'b0);
        send_chunk({CHUNK_BYTES{8'hAA}}, {CHUNK_BYTES{DASH}}, 1'b0);
        send_chunk({CHUNK_BYTES{8'hAA}}, {CHUNK_BYTES{8'hAA}}, 1'b1);
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_PADDED_LENGTH, CNT_MAX);
        write_reg(REG_GAP_CODE, t_cnt'(21'h1FFF00));
        release_cfg();
        send_chunk(64'h0102_0304_0506_0700, '1, 1'b1);
        drain_results();
        write_reg(REG_GAP_CODE, t_cnt'(8'hFF));
        write_reg(REG_PADDED_LENGTH, t_cnt'(77));
        release_cfg();
        send_chunk(64'hFF00_FF00_1111_2222, 64'h0000_FFFF_1111_3333, 1'b1);
        drain_results();
        write_reg(REG_UNUSED_LOW, t_cnt'($urandom));
        write_reg(REG_UNUSED_TOP, CNT_MAX);
        release_cfg();
        send_chunk({CHUNK_BYTES{8'hFF}}, 64'h0, 1'b1);
        drain_results();
        write_reg(REG_PADDED_LENGTH, t_cnt'(1048576));
        release_cfg();
        send_chunk(64'hFFFF_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);
        drain_results();
        write_reg(REG_PADDED_LENGTH, '0);
        write_reg(REG_GAP_CODE, t_cnt'(DASH));
        release_cfg();
        send_chunk(64'h1, 64'h1, 1'b1);
        send_chunk({CHUNK_BYTES{DASH}}, '0, 1'b1);
        drain_results();
    endtask

    task automatic pick_config();
        t_cnt pad;
        t_cnt gap_data;
        case ($urandom_range(5))
            0:       pad = '0;
            1:       pad = CNT_MAX;
            2:       pad = t_cnt'(1048576);
            3:       pad = t_cnt'(128 * $urandom_range(0, 4));
            4:       pad = t_cnt'($urandom_range(0, 200));
            default: pad = t_cnt'($urandom);
        endcase
        case ($urandom_range(3))
            0:       gap_data = t_cnt'(DASH);
            1:       gap_data = t_cnt'(0);
            2:       gap_data = t_cnt'(8'hFF);
            default: gap_data = t_cnt'($urandom);
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(t_cfg_index'($urandom_range(2, 255)), t_cnt'($urandom));
        end
        if ($urandom_range(1) == 0) begin
            write_reg(REG_PADDED_LENGTH, pad);
            write_reg(REG_GAP_CODE, gap_data);
        end else begin
            write_reg(REG_GAP_CODE, gap_data);
            write_reg(REG_PADDED_LENGTH, pad);
        end
        release_cfg();
    endtask

    task automatic test_random_traffic();
        int     phase;
        int     blk;
        int     sent;
        int     seq_len;
        int     k;
        t_chunk a;
        t_chunk b;
        logic   is_last;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 7;
                    snk_idle_pct = 58;
                end
                1: begin
                    src_idle_pct = 58;
                    snk_idle_pct = 7;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            for (blk = 0; blk < 3; blk++) begin
                pick_config();
                sent    = 0;
                is_last = 1'b1;
                while (sent < BLOCK_ITEMS) begin
                    seq_len = ($urandom_range(9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 12);
                    for (k = 0; k < seq_len; k++) begin
                        is_last = (k == seq_len - 1);
                        if ($urandom_range(9) == 0) begin
                            a = {$urandom, $urandom};
                            b = {$urandom, $urandom};
                            if ($urandom_range(3) == 0) begin
                                is_last = 1'($urandom_range(1));
                            end
                        end else begin
                            make_residue_pair(gap_sym_reg, a, b);
                        end
                        send_chunk(a, b, is_last);
                        sent++;
                    end
                end
                if (!is_last) begin
                    make_residue_pair(gap_sym_reg, a, b);
                    send_chunk(a, b, 1'b1);
                end
                drain_results();
            end
        end
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_chunk_a    = '0;
        i_chunk_b    = '0;
        i_last_chunk = 1'b0;
        i_ready      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        error_count  = 0;
        src_idle_pct = 7;
        snk_idle_pct = 58;
        pad_len_reg  = '0;
        gap_sym_reg  = GAP_CODE_RST;
        mis_total    = '0;
        gap_total    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_lane_classes();
        test_register_extremes();
        test_random_traffic();

        if (expected_tallies.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected transactions never arrived",
                     $time, expected_tallies.size());
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
